### rtl/sjis_pkg.sv
// Package with the types, constants and helper functions of the Shift-JIS glyph placer.
`timescale 1ns / 1ps
`default_nettype none

package sjis_pkg;

  // Width of the pen position registers.
  localparam int POS_BITS  = 16;
  // Working width for clamping: wide enough for the pen, the 16-bit ports and one carry.
  localparam int WIDE_BITS = (POS_BITS > 16) ? POS_BITS : 16;

  typedef logic signed [POS_BITS-1:0] pos_t;
  typedef logic signed [WIDE_BITS:0]  wide_t;

  localparam wide_t POS_MAX_W = wide_t'({1'b0, {(POS_BITS-1){1'b1}}});
  localparam wide_t POS_MIN_W = ~POS_MAX_W;

  localparam logic signed [15:0] X_MAX = 16'sh7FFF;
  localparam logic signed [15:0] X_MIN = 16'sh8000;

  localparam logic [7:0] LEAD_A_LO  = 8'h81;
  localparam logic [7:0] LEAD_A_HI  = 8'h9F;
  localparam logic [7:0] LEAD_B_LO  = 8'hE0;
  localparam logic [7:0] LEAD_B_HI  = 8'hFC;
  localparam logic [7:0] TRAIL_A_LO = 8'h40;
  localparam logic [7:0] TRAIL_A_HI = 8'h7E;
  localparam logic [7:0] TRAIL_B_LO = 8'h80;
  localparam logic [7:0] TRAIL_B_HI = 8'h9E;
  localparam logic [7:0] ROW_B_BASE = 8'd62;
  localparam logic [7:0] CODE_BIAS  = 8'd33;

  // Cell plus bias, as an offset added to the trail byte (modulo 2^16).
  localparam logic [15:0] CELL_ADJ_A   = 16'(-31);   // b - 0x40 + 33
  localparam logic [15:0] CELL_ADJ_B   = 16'(-32);   // b - 0x80 + 63 + 33
  localparam logic [15:0] CELL_ADJ_BAD = 16'(-126);  // b - 0x9F + 33

  localparam logic [1:0] FONT_12 = 2'd0;
  localparam logic [1:0] FONT_14 = 2'd1;

  typedef struct packed {
    logic [7:0]         byte_value;
    logic               first_of_string;
    logic signed [15:0] start_x;
  } in_item_t;

  typedef struct packed {
    logic [15:0]        glyph_code;
    logic               wide_glyph;
    logic signed [15:0] draw_x;
  } out_item_t;

  function automatic pos_t sat_pos(wide_t v);
    wide_t c;
    c = v;
    if (v > POS_MAX_W) c = POS_MAX_W;
    else if (v < POS_MIN_W) c = POS_MIN_W;
    return pos_t'(c[POS_BITS-1:0]);
  endfunction

  function automatic logic signed [15:0] sat_out_x(pos_t p);
    wide_t v;
    wide_t c;
    v = wide_t'(p);
    c = v;
    if (v > wide_t'(X_MAX)) c = wide_t'(X_MAX);
    else if (v < wide_t'(X_MIN)) c = wide_t'(X_MIN);
    return c[15:0];
  endfunction

  function automatic logic is_lead(logic [7:0] b);
    return ((b >= LEAD_A_LO) && (b <= LEAD_A_HI)) || ((b >= LEAD_B_LO) && (b <= LEAD_B_HI));
  endfunction

  function automatic logic [3:0] half_cell(logic [1:0] font);
    logic [3:0] h;
    unique case (font)
      FONT_12: h = 4'd6;
      FONT_14: h = 4'd7;
      default: h = 4'd8;
    endcase
    return h;
  endfunction

  // JIS X 0208 code of a lead and trail pair, with the bias of 33 on row and cell.
  function automatic logic [15:0] pair_code(logic [7:0] lead, logic [7:0] trail);
    logic [7:0]  row;
    logic [15:0] adj;
    if (lead <= LEAD_A_HI) row = 8'((lead - LEAD_A_LO) << 1);
    else row = 8'(((lead - LEAD_B_LO) << 1) + ROW_B_BASE);
    if ((trail >= TRAIL_A_LO) && (trail <= TRAIL_A_HI)) begin
      adj = CELL_ADJ_A;
    end else if ((trail >= TRAIL_B_LO) && (trail <= TRAIL_B_HI)) begin
      adj = CELL_ADJ_B;
    end else begin
      adj = CELL_ADJ_BAD;
      row = row + 8'd1;
    end
    return {row + CODE_BIAS, 8'h00} + {8'h00, trail} + adj;
  endfunction

endpackage

`default_nettype wire

### rtl/sjis_glyph_code_placer_core.sv
// Top level of the Shift-JIS glyph placer: byte decode, pen tracking and output skid.
`timescale 1ns / 1ps
`default_nettype none

// This block takes one Shift-JIS byte per transaction and returns at most one glyph
// transaction for it from a registered output. It sustains one byte per cycle while the
// skid stage is empty: all decode and pen arithmetic is one combinational pass from the
// input port into the state registers and the result or skid register. A second result
// register (skid stage) holds one result while the consumer stalls, so in_stall rises
// only when that stage is occupied. The pen advances by half the cell width on every
// non-zero byte and saturates at the signed pen limits. A lead byte produces no result;
// the following byte emits the JIS X 0208 row and cell code drawn at the lead byte's
// position. A zero byte produces no result and drops any pending lead. The font size
// register may only be written while the block is idle; writes are always taken.
module sjis_glyph_code_placer_core (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       in_valid,
  output logic                      in_stall,
  input  sjis_pkg::in_item_t        in_data,
  output logic                      out_valid,
  input  wire                       out_stall,
  output sjis_pkg::out_item_t       out_data,
  input  wire                       cfg_valid,
  output logic                      cfg_ready,
  input  wire [1:0]                 cfg_data
);

  logic [1:0]           font_size_r;
  logic [7:0]           pending_r, pending_nxt;
  sjis_pkg::pos_t       pen_x_r, pen_x_nxt;
  sjis_pkg::pos_t       lead_x_r, lead_x_nxt;

  logic                 out_valid_r, out_valid_nxt;
  sjis_pkg::out_item_t  out_item_r, out_item_nxt;
  logic                 skid_valid_r, skid_valid_nxt;
  sjis_pkg::out_item_t  skid_item_r, skid_item_nxt;

  logic                 in_acc;
  logic                 out_take;
  logic                 res_valid;
  sjis_pkg::out_item_t  res_item;
  logic [7:0]           pend_eff;
  sjis_pkg::pos_t       pen_eff;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign in_acc    = in_valid && !skid_valid_r;
  assign out_take  = out_valid_r && !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  // Decode of one byte. A first byte of a string first reloads the pen and clears the lead.
  always_comb begin
    pend_eff    = in_data.first_of_string ? 8'h00 : pending_r;
    pen_eff     = in_data.first_of_string ?
                  sjis_pkg::sat_pos(sjis_pkg::wide_t'(in_data.start_x)) : pen_x_r;
    pending_nxt = pend_eff;
    lead_x_nxt  = lead_x_r;
    pen_x_nxt   = pen_eff;
    res_valid   = 1'b0;
    res_item    = '{glyph_code: {8'h00, in_data.byte_value}, wide_glyph: 1'b0,
                    draw_x: sjis_pkg::sat_out_x(pen_eff)};
    if (in_data.byte_value == 8'h00) begin
      // End of string: the pen stays where it is.
      pending_nxt = 8'h00;
    end else begin
      if (pend_eff == 8'h00) begin
        if (sjis_pkg::is_lead(in_data.byte_value)) begin
          pending_nxt = in_data.byte_value;
          lead_x_nxt  = pen_eff;
        end else begin
          res_valid = 1'b1;
        end
      end else begin
        res_valid           = 1'b1;
        res_item.glyph_code = sjis_pkg::pair_code(pend_eff, in_data.byte_value);
        res_item.wide_glyph = 1'b1;
        res_item.draw_x     = sjis_pkg::sat_out_x(lead_x_r);
        pending_nxt         = 8'h00;
      end
      pen_x_nxt = sjis_pkg::sat_pos(sjis_pkg::wide_t'(pen_eff) +
                  sjis_pkg::wide_t'({1'b0, sjis_pkg::half_cell(font_size_r)}));
    end
  end

  // Output register with one skid stage behind it.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_item_nxt   = out_item_r;
    skid_valid_nxt = skid_valid_r;
    skid_item_nxt  = skid_item_r;
    if (!out_valid_r || out_take) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_item_nxt   = skid_item_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = in_acc && res_valid;
        out_item_nxt  = res_item;
      end
    end else if (in_acc && res_valid) begin
      skid_valid_nxt = 1'b1;
      skid_item_nxt  = res_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      font_size_r  <= 2'd0;
      pending_r    <= 8'h00;
      pen_x_r      <= '0;
      lead_x_r     <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) font_size_r <= cfg_data;
      if (in_acc) begin
        pending_r <= pending_nxt;
        pen_x_r   <= pen_x_nxt;
        lead_x_r  <= lead_x_nxt;
      end
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r  <= out_item_nxt;
    skid_item_r <= skid_item_nxt;
  end

  // The skid stage only fills behind a held result.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid stage holds a result while the output register is empty");

  // A zero byte always leaves no lead pending.
  a_zero_drops_lead: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_data.byte_value == 8'h00) |=> pending_r == 8'h00)
    else $error("lead byte survived the end of a string");

  // A zero byte inside a string does not move the pen.
  a_zero_keeps_pen: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_data.byte_value == 8'h00) && !in_data.first_of_string |=> $stable(pen_x_r))
    else $error("pen moved on the end of a string");

  // Wide glyph rows carry the bias and stay between 33 and 152.
  a_wide_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.wide_glyph |->
      (out_item_r.glyph_code[15:8] >= 8'd33) && (out_item_r.glyph_code[15:8] <= 8'd152))
    else $error("wide glyph row out of range");

endmodule

`default_nettype wire

### tb/sv/sjis_glyph_code_placer_core_tb.sv
// Self-checking testbench for the Shift-JIS glyph placer core.
`timescale 1ns / 1ps

module sjis_glyph_code_placer_core_tb;

  // The package names only the two smaller cells, so the 16 px codes are named here.
  localparam logic [1:0] FONT_16     = 2'd2;
  localparam logic [1:0] FONT_16_ALT = 2'd3;

  // Cycles without any transaction before the run is declared hung.
  localparam int HANG_LIMIT   = 5000;
  // Settling cycles waited after the last predicted glyph has arrived.
  localparam int SETTLE_CYCLES = 4;
  localparam int ITEMS_PER_PHASE = 175;

  // Predicts the glyph transactions of the core and keeps those still to arrive.
  class glyph_scoreboard;
    sjis_pkg::out_item_t pending_glyphs[$];
    logic [1:0]  font;
    logic [7:0]  lead_byte;
    longint      pen;
    longint      lead_pen;
    int          mismatches;

    function new();
      font = sjis_pkg::FONT_12;
      lead_byte = 8'h00;
      pen = 0;
      lead_pen = 0;
      mismatches = 0;
    endfunction

    function void set_font(logic [1:0] f);
      font = f;
    endfunction

    function longint clamp_pen(longint v);
      longint hi;
      hi = (longint'(1) <<< (sjis_pkg::POS_BITS - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
    endfunction

    function logic [15:0] screen_x(longint v);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return 16'(v);
    endfunction

    function void note_byte(sjis_pkg::in_item_t it);
      sjis_pkg::out_item_t glyph;
      logic [7:0] b;
      int row;
      int col;
      b = it.byte_value;
      if (it.first_of_string) begin
        pen = clamp_pen(longint'($signed(it.start_x)));
        lead_byte = 8'h00;
      end
      // A zero byte ends the string: nothing is drawn and the pen stays put.
      if (b == 8'h00) begin
        lead_byte = 8'h00;
        return;
      end
      if (lead_byte == 8'h00) begin
        if ((b >= sjis_pkg::LEAD_A_LO && b <= sjis_pkg::LEAD_A_HI) ||
            (b >= sjis_pkg::LEAD_B_LO && b <= sjis_pkg::LEAD_B_HI)) begin
          lead_byte = b;
          lead_pen = pen;
        end else begin
          glyph.glyph_code = {8'h00, b};
          glyph.wide_glyph = 1'b0;
          glyph.draw_x = screen_x(pen);
          pending_glyphs.push_back(glyph);
        end
      end else begin
        if (lead_byte <= sjis_pkg::LEAD_A_HI) begin
          row = (int'(lead_byte) - int'(sjis_pkg::LEAD_A_LO)) * 2;
        end else begin
          row = (int'(lead_byte) - int'(sjis_pkg::LEAD_B_LO)) * 2 + int'(sjis_pkg::ROW_B_BASE);
        end
        if (b >= sjis_pkg::TRAIL_A_LO && b <= sjis_pkg::TRAIL_A_HI) begin
          col = int'(b) - int'(sjis_pkg::TRAIL_A_LO);
        end else if (b >= sjis_pkg::TRAIL_B_LO && b <= sjis_pkg::TRAIL_B_HI) begin
          col = int'(b) - int'(sjis_pkg::TRAIL_B_LO) + 63;
        end else begin
          // Out-of-range trail bytes decode as the odd row; the cell may go negative.
          col = int'(b) - 'h9F;
          row = row + 1;
        end
        glyph.glyph_code = 16'((row + int'(sjis_pkg::CODE_BIAS)) * 256 + col +
                               int'(sjis_pkg::CODE_BIAS));
        glyph.wide_glyph = 1'b1;
        glyph.draw_x = screen_x(lead_pen);
        pending_glyphs.push_back(glyph);
        lead_byte = 8'h00;
      end
      case (font)
        sjis_pkg::FONT_12: pen = clamp_pen(pen + 6);
        sjis_pkg::FONT_14: pen = clamp_pen(pen + 7);
        default: pen = clamp_pen(pen + 8);
      endcase
    endfunction

    function void check_glyph(sjis_pkg::out_item_t got);
      sjis_pkg::out_item_t want;
      if (pending_glyphs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected glyph: code %h wide %0d x %0d",
                   got.glyph_code, got.wide_glyph, got.draw_x);
        return;
      end
      want = pending_glyphs.pop_front();
      if (got.glyph_code !== want.glyph_code || got.wide_glyph !== want.wide_glyph ||
          got.draw_x !== want.draw_x) begin
        mismatches++;
        if (mismatches <= 10)
          $display("glyph mismatch: expected code %h wide %0d x %0d, got code %h wide %0d x %0d",
                   want.glyph_code, want.wide_glyph, want.draw_x,
                   got.glyph_code, got.wide_glyph, got.draw_x);
      end
    endfunction

    function void check_drained();
      if (pending_glyphs.size() != 0) begin
        mismatches += pending_glyphs.size();
        $display("%0d expected glyphs never arrived", pending_glyphs.size());
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  sjis_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  sjis_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_data = 2'd0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;

  glyph_scoreboard glyphs = new();
  sjis_pkg::in_item_t byte_stream[$];

  sjis_glyph_code_placer_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // The consumer stalls at random, at the rate of the current phase.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Every glyph transaction is compared with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      glyphs.check_glyph(out_data);
    end
  end

  // The watchdog restarts whenever any channel completes a transaction.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= HANG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", quiet_cycles);
        $display("RESULT: ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic sjis_pkg::in_item_t text_byte(logic [7:0] b, logic first = 1'b0,
                                                   logic [15:0] x = 16'h0000);
    sjis_pkg::in_item_t it;
    it.byte_value = b;
    it.first_of_string = first;
    it.start_x = x;
    return it;
  endfunction

  // Presents one byte, with random idle cycles ahead of it, and holds it until taken.
  task automatic send_byte(sjis_pkg::in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    glyphs.note_byte(it);
  endtask

  task automatic send_stream();
    while (byte_stream.size() != 0) send_byte(byte_stream.pop_front());
  endtask

  // Stops the byte stream and lets the core finish everything it holds.
  task automatic quiesce();
    in_valid <= 1'b0;
    while (glyphs.pending_glyphs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_font(logic [1:0] f);
    quiesce();
    cfg_valid <= 1'b1;
    cfg_data <= f;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    glyphs.set_font(f);
  endtask

  function automatic logic [15:0] random_origin();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'(32767 - $urandom_range(60));
      2: return 16'(-32768 + $urandom_range(60));
      default: return 16'($urandom_range(400));
    endcase
  endfunction

  function automatic logic [7:0] random_lead();
    return $urandom_range(1) ? 8'($urandom_range('h81, 'h9F)) : 8'($urandom_range('hE0, 'hFC));
  endfunction

  // Appends one string: mostly well-formed text, sometimes raw noise.
  function automatic void add_string();
    int len;
    int kind;
    logic [7:0] b;
    len = $urandom_range(1, 12);
    if ($urandom_range(99) < 15) begin
      repeat (len) byte_stream.push_back(text_byte(8'($urandom), 1'($urandom), 16'($urandom)));
      return;
    end
    byte_stream.push_back(text_byte(8'($urandom_range(1, 'h7F)), 1'b1, random_origin()));
    repeat (len) begin
      kind = $urandom_range(9);
      if (kind < 4) begin
        b = $urandom_range(1) ? 8'($urandom_range(1, 'h7F)) : 8'($urandom_range('hA0, 'hDF));
        byte_stream.push_back(text_byte(b, 1'b0, 16'($urandom)));
      end else begin
        byte_stream.push_back(text_byte(random_lead(), 1'b0, 16'($urandom)));
        if (kind < 9) begin
          b = $urandom_range(1) ? 8'($urandom_range('h40, 'h7E))
                                : 8'($urandom_range('h80, 'h9E));
        end else begin
          case ($urandom_range(2))
            0: b = 8'($urandom_range(1, 'h3F));
            1: b = 8'h7F;
            default: b = 8'($urandom_range('h9F, 'hFF));
          endcase
        end
        byte_stream.push_back(text_byte(b, 1'b0, 16'($urandom)));
      end
    end
    if ($urandom_range(99) < 70) byte_stream.push_back(text_byte(8'h00, 1'b0, 16'($urandom)));
  endfunction

  initial begin
    int idle_by_phase[4];
    int stall_by_phase[4];
    logic [1:0] font_by_phase[4];

    idle_by_phase  = '{0, 52, 0, 10};
    stall_by_phase = '{0, 0, 52, 10};
    font_by_phase  = '{FONT_16, sjis_pkg::FONT_12, FONT_16_ALT, sjis_pkg::FONT_14};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed text at the reset font: single bytes at the edges of the narrow set,
    // the lowest and highest pairs of both lead ranges, bad trail bytes on both sides,
    // a lead cut short by a zero byte and by a new string, and both pen limits.
    byte_stream.push_back(text_byte(8'h41, 1'b1, 16'h0000));
    byte_stream.push_back(text_byte(8'h01));
    byte_stream.push_back(text_byte(8'h7F));
    byte_stream.push_back(text_byte(8'h80));
    byte_stream.push_back(text_byte(8'hA0));
    byte_stream.push_back(text_byte(8'hFD));
    byte_stream.push_back(text_byte(8'hFF));
    byte_stream.push_back(text_byte(8'h81));
    byte_stream.push_back(text_byte(8'h40));
    byte_stream.push_back(text_byte(8'h9F));
    byte_stream.push_back(text_byte(8'h7E));
    byte_stream.push_back(text_byte(8'hE0));
    byte_stream.push_back(text_byte(8'h80));
    byte_stream.push_back(text_byte(8'hFC));
    byte_stream.push_back(text_byte(8'h9E));
    byte_stream.push_back(text_byte(8'h81));
    byte_stream.push_back(text_byte(8'hFC));
    byte_stream.push_back(text_byte(8'hFC));
    byte_stream.push_back(text_byte(8'h01));
    byte_stream.push_back(text_byte(8'h88));
    byte_stream.push_back(text_byte(8'h00));
    byte_stream.push_back(text_byte(8'h89));
    byte_stream.push_back(text_byte(8'h41, 1'b1, 16'h7FFF));
    byte_stream.push_back(text_byte(8'h42));
    byte_stream.push_back(text_byte(8'hE5, 1'b1, 16'h8000));
    byte_stream.push_back(text_byte(8'h9F));
    send_stream();

    // A font change between lead and trail must leave the pair at the lead's position.
    send_byte(text_byte(8'h82, 1'b1, 16'h0100));
    write_font(sjis_pkg::FONT_14);
    send_byte(text_byte(8'h60));
    send_byte(text_byte(8'h41));

    // Random text in phases with different pacing on each side and a new font each time.
    for (int p = 0; p < 4; p++) begin
      write_font(font_by_phase[p]);
      send_idle_pct = idle_by_phase[p];
      recv_stall_pct = stall_by_phase[p];
      while (byte_stream.size() < ITEMS_PER_PHASE) add_string();
      send_stream();
    end

    quiesce();
    repeat (10) @(posedge clk);
    glyphs.check_drained();
    if (glyphs.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
